// ===== hw/rtl/rlr_pkg.sv =====
// Shared types and constants for the Rice residual LPC restorer.
// Used by rlr_ctrl, rlr_dpath and rice_residual_lpc_restorer; no dependencies.
`default_nettype none

package rlr_pkg;

    localparam int MAX_ORDER = 32;
    localparam int MAX_BLOCK = 65536;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ORD_W     = $clog2(MAX_ORDER) + 1;
    localparam int LEN_W     = $clog2(MAX_BLOCK) + 1;

    localparam logic [1:0] MODE_COEF = 2'd0;
    localparam logic [1:0] MODE_WARM = 2'd1;
    localparam logic [1:0] MODE_BYTE = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_METHOD = 2'd1;
    localparam logic [1:0] ERR_ESCAPE = 2'd2;

    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_SHIFT = 2'd1;
    localparam logic [1:0] CFG_LEN   = 2'd2;

    localparam logic [4:0] ESC_NARROW = 5'd15;
    localparam logic [4:0] ESC_WIDE   = 5'd31;

    typedef enum logic [2:0] {
        PH_METHOD, PH_ORDER, PH_PARAM, PH_UNARY, PH_REM, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ESEL_WARM, ESEL_RES, ESEL_ERR
    } t_esel;

    typedef struct packed {
        logic             coef_wr;
        logic             latch;
        logic             push;
        logic             mac_clear;
        logic             mac_mul;
        logic             mac_add;
        logic [IDX_W-1:0] mac_idx;
        logic             u_clr;
        logic             u_inc;
        logic             u_shift;
        logic             u_setbit;
        logic [4:0]       u_bitpos;
        logic [4:0]       rice;
        logic             emit;
        t_esel            esel;
        logic             blk_end;
        logic [1:0]       err;
        logic             flush;
    } t_cmd;

    typedef struct packed {
        logic can_emit;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/rice_residual_lpc_restorer.sv =====
// Top level of the Rice residual LPC restorer: configuration registers,
// controller and datapath. Depends on rlr_pkg, rlr_ctrl and rlr_dpath.
`default_nettype none

// Rebuilds a block of samples from predictor coefficients, warm-up samples and
// a Rice-coded residual byte stream. A coefficient is written as it is accepted.
// A warm-up transaction passes through an emit state, which waits for room in
// the result path, and a flush state. A stream byte is parsed bit by bit and then
// flushed; every residual completed in the byte runs the prediction through a
// single shared 32x32 multiply-accumulate unit, one tap per cycle, before it is
// emitted. No new transaction is accepted until the byte is done. Results leave
// through a one-deep pending stage and an output register, so the result
// stream may stall without losing data; a stalled output holds the parser.
// Configuration writes restart the block and must be made while idle.
module rice_residual_lpc_restorer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // tap_index[4:0], value[36:5], stream_byte[44:37]
    input  wire logic [1:0]  i_s_tuser,   // mode[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // sample[31:0]
    output logic [2:0]       o_m_tuser,   // block_end[0], error_code[2:1]
    output logic             o_m_tlast,   // last result of the input transaction
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data
);
    import rlr_pkg::*;

    logic [5:0]       r_order;
    logic [4:0]       r_shift;
    logic [16:0]      r_len;
    logic [ORD_W-1:0] eff_ord;
    logic [LEN_W-1:0] eff_len;
    logic             in_acc, ready, blk_end;
    logic [1:0]       err;
    t_cmd             cmd;
    t_stat            stat;
    t_phase           phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0; r_shift <= '0; r_len <= 17'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORDER: r_order <= i_cfg_data[5:0];
                CFG_SHIFT: r_shift <= i_cfg_data[4:0];
                CFG_LEN:   r_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp order and length to what the stores can hold
    assign eff_ord = (r_order > 6'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ORD_W'(r_order);
    assign eff_len = (r_len > 17'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : LEN_W'(r_len);

    assign in_acc = i_s_tvalid && ready;
    assign o_s_tready = ready;

    rlr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_acc (in_acc),
        .i_mode   (i_s_tuser),
        .i_byte   (i_s_tdata[44:37]),
        .i_cfg_we (i_cfg_we),
        .i_ord    (eff_ord),
        .i_len    (eff_len),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_ready  (ready),
        .o_phase  (phase)
    );

    rlr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_tap      (i_s_tdata[IDX_W-1:0]),
        .i_value    (i_s_tdata[36:5]),
        .i_shift    (r_shift),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_sample   (o_m_tdata),
        .o_blk_end  (blk_end),
        .o_err      (err),
        .o_last     (o_m_tlast)
    );

    assign o_m_tuser = {err, blk_end};

`ifndef ASSERT_OFF
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && err != ERR_NONE) |-> (o_m_tdata == 32'd0 && !blk_end))
        else $error("error result carries sample or block end");
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (phase == PH_METHOD))
        else $error("register write did not restart the block");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.mac_mul) |-> !o_s_tready)
        else $error("input taken while a residual is in progress");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rlr_ctrl.sv =====
// Controller for the Rice residual LPC restorer: bit parser and MAC sequencer.
// Depends on rlr_pkg; drives rlr_dpath through t_cmd.
`default_nettype none

module rlr_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_acc,
    input  wire logic [1:0]                i_mode,
    input  wire logic [7:0]                i_byte,
    input  wire logic                      i_cfg_we,
    input  wire logic [rlr_pkg::ORD_W-1:0] i_ord,
    input  wire logic [rlr_pkg::LEN_W-1:0] i_len,
    input  wire rlr_pkg::t_stat            i_stat,
    output rlr_pkg::t_cmd                  o_cmd,
    output logic                           o_ready,
    output rlr_pkg::t_phase                o_phase
);
    import rlr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BIT, S_MAC, S_EMIT, S_WARM, S_FLUSH
    } t_state;

    t_state             r_state, n_state;
    logic [7:0]         r_byte, n_byte;
    logic [2:0]         r_k, n_k;
    t_phase             r_phase, n_phase;
    logic [5:0]         r_fs, n_fs;
    logic [4:0]         r_seen, n_seen;
    logic [4:0]         r_rice, n_rice;
    logic               r_wide, n_wide;
    logic [3:0]         r_po, n_po;
    logic [15:0]        r_pc, n_pc;
    logic [LEN_W-1:0]   r_prem, n_prem;
    logic [LEN_W-1:0]   r_sd, n_sd;
    logic [ORD_W-1:0]   r_cnt, n_cnt;

    logic               bit_in;
    logic [5:0]         fsb;
    logic [4:0]         seen1;
    logic [LEN_W-1:0]   per, plen, sd_inc, prem_dec;
    logic [15:0]        pc1;
    logic               advance;

    always_comb begin
        n_state = r_state; n_byte = r_byte; n_k = r_k; n_phase = r_phase;
        n_fs = r_fs; n_seen = r_seen; n_rice = r_rice; n_wide = r_wide;
        n_po = r_po; n_pc = r_pc; n_prem = r_prem; n_sd = r_sd; n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.rice = r_rice;
        o_cmd.mac_idx = r_cnt[IDX_W-1:0];
        o_cmd.u_bitpos = r_rice - 5'd1 - r_seen;
        o_ready = 1'b0;
        advance = 1'b0;
        bit_in = r_byte[7];
        fsb = {r_fs[4:0], bit_in};
        seen1 = r_seen + 5'd1;
        per = i_len >> r_po;
        plen = (per > LEN_W'(i_ord)) ? per - LEN_W'(i_ord) : '0;
        sd_inc = (&r_sd) ? r_sd : r_sd + LEN_W'(1);
        prem_dec = (r_prem != '0) ? r_prem - LEN_W'(1) : '0;
        pc1 = r_pc + 16'd1;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_acc) begin
                    if ((i_mode == MODE_COEF || i_mode == MODE_WARM) && r_phase == PH_DONE) begin
                        n_phase = PH_METHOD; n_fs = '0; n_seen = '0; n_rice = '0;
                        n_wide = 1'b0; n_po = '0; n_pc = '0; n_prem = '0; n_sd = '0;
                        o_cmd.u_clr = 1'b1;
                    end
                    case (i_mode)
                        MODE_COEF: o_cmd.coef_wr = 1'b1;
                        MODE_WARM: begin
                            o_cmd.latch = 1'b1;
                            n_state = S_WARM;
                        end
                        MODE_BYTE: begin
                            n_byte = i_byte;
                            n_k = '0;
                            n_state = S_BIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_WARM: begin
                if (i_stat.can_emit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = ESEL_WARM;
                    o_cmd.push = 1'b1;
                    o_cmd.blk_end = (sd_inc == i_len);
                    n_sd = sd_inc;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state = S_IDLE;
            end
            S_BIT: begin
                advance = 1'b1;
                case (r_phase)
                    PH_METHOD: begin
                        n_fs = fsb; n_seen = seen1;
                        if (seen1 == 5'd2) begin
                            if (fsb > 6'd1) begin
                                if (i_stat.can_emit) begin
                                    o_cmd.emit = 1'b1; o_cmd.esel = ESEL_ERR;
                                    o_cmd.err = ERR_METHOD;
                                    n_phase = PH_DONE;
                                end else begin
                                    advance = 1'b0; n_fs = r_fs; n_seen = r_seen;
                                end
                            end else begin
                                n_wide = fsb[0]; n_fs = '0; n_seen = '0;
                                n_phase = PH_ORDER;
                            end
                        end
                    end
                    PH_ORDER: begin
                        n_fs = fsb; n_seen = seen1;
                        if (seen1 == 5'd4) begin
                            n_po = fsb[3:0]; n_pc = '0; n_fs = '0; n_seen = '0;
                            n_phase = PH_PARAM;
                        end
                    end
                    PH_PARAM: begin
                        n_fs = fsb; n_seen = seen1;
                        if (seen1 == (r_wide ? 5'd5 : 5'd4)) begin
                            if (fsb[4:0] == (r_wide ? ESC_WIDE : ESC_NARROW)) begin
                                if (i_stat.can_emit) begin
                                    o_cmd.emit = 1'b1; o_cmd.esel = ESEL_ERR;
                                    o_cmd.err = ERR_ESCAPE;
                                    n_phase = PH_DONE;
                                end else begin
                                    advance = 1'b0; n_fs = r_fs; n_seen = r_seen;
                                end
                            end else begin
                                n_rice = fsb[4:0]; n_fs = '0; n_seen = '0;
                                if (r_pc == '0 ? plen == '0 : per == '0) begin
                                    n_pc = pc1;
                                    n_phase = ({1'b0, pc1} >= (LEN_W'(1) << r_po)) ?
                                              PH_DONE : PH_PARAM;
                                end else begin
                                    n_prem = (r_pc == '0) ? plen : per;
                                    o_cmd.u_clr = 1'b1;
                                    n_phase = PH_UNARY;
                                end
                            end
                        end
                    end
                    PH_UNARY: begin
                        if (!bit_in) begin
                            o_cmd.u_inc = 1'b1;
                        end else begin
                            o_cmd.u_shift = 1'b1;
                            if (r_rice == '0) begin
                                advance = 1'b0;
                                o_cmd.mac_clear = 1'b1; n_cnt = '0; n_state = S_MAC;
                            end else begin
                                n_seen = '0; n_phase = PH_REM;
                            end
                        end
                    end
                    PH_REM: begin
                        o_cmd.u_setbit = bit_in;
                        n_seen = seen1;
                        if (seen1 >= r_rice) begin
                            advance = 1'b0;
                            o_cmd.mac_clear = 1'b1; n_cnt = '0; n_state = S_MAC;
                        end
                    end
                    default: ;
                endcase
            end
            S_MAC: begin
                o_cmd.mac_mul = (r_cnt < i_ord);
                o_cmd.mac_add = (r_cnt != '0);
                n_cnt = r_cnt + ORD_W'(1);
                if (r_cnt == i_ord) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.can_emit) begin
                    o_cmd.emit = 1'b1; o_cmd.esel = ESEL_RES;
                    o_cmd.push = 1'b1; o_cmd.u_clr = 1'b1;
                    n_sd = sd_inc;
                    n_prem = prem_dec;
                    n_phase = PH_UNARY;
                    if (prem_dec == '0) begin
                        n_pc = pc1; n_fs = '0; n_seen = '0;
                        n_phase = ({1'b0, pc1} >= (LEN_W'(1) << r_po)) ? PH_DONE : PH_PARAM;
                    end
                    o_cmd.blk_end = (n_phase == PH_DONE);
                    advance = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (advance) begin
            n_byte = {r_byte[6:0], 1'b0};
            n_k = r_k + 3'd1;
            n_state = (r_k == 3'd7) ? S_FLUSH : S_BIT;
        end

        // a register write starts a new block
        if (i_cfg_we) begin
            n_phase = PH_METHOD; n_fs = '0; n_seen = '0; n_rice = '0;
            n_wide = 1'b0; n_po = '0; n_pc = '0; n_prem = '0; n_sd = '0;
            o_cmd.u_clr = 1'b1;
        end
    end

    assign o_phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_byte <= '0; r_k <= '0; r_phase <= PH_METHOD;
            r_fs <= '0; r_seen <= '0; r_rice <= '0; r_wide <= 1'b0; r_po <= '0;
            r_pc <= '0; r_prem <= '0; r_sd <= '0; r_cnt <= '0;
        end else begin
            r_state <= n_state; r_byte <= n_byte; r_k <= n_k; r_phase <= n_phase;
            r_fs <= n_fs; r_seen <= n_seen; r_rice <= n_rice; r_wide <= n_wide;
            r_po <= n_po; r_pc <= n_pc; r_prem <= n_prem; r_sd <= n_sd; r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rlr_dpath.sv =====
// Datapath for the Rice residual LPC restorer: tap stores, shared MAC,
// residual assembly and the pending/output result registers. Depends on rlr_pkg.
`default_nettype none

module rlr_dpath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rlr_pkg::t_cmd             i_cmd,
    input  wire logic [rlr_pkg::IDX_W-1:0] i_tap,
    input  wire logic [31:0]               i_value,
    input  wire logic [4:0]                i_shift,
    input  wire logic                      i_m_tready,
    output rlr_pkg::t_stat                 o_stat,
    output logic                           o_m_tvalid,
    output logic [31:0]                    o_sample,
    output logic                           o_blk_end,
    output logic [1:0]                     o_err,
    output logic                           o_last
);
    import rlr_pkg::*;

    logic [31:0] r_coef [MAX_ORDER];
    logic [31:0] r_hist [MAX_ORDER];
    logic [31:0] r_val, r_prod, r_acc, r_u;
    logic [31:0] pred, zz, smp;
    logic        r_pv, r_pe, r_pl;
    logic [31:0] r_ps;
    logic [1:0]  r_perr;
    logic        r_ov, r_oe, r_ol;
    logic [31:0] r_os;
    logic [1:0]  r_oerr;
    logic        out_free, move;

    assign pred = 32'($signed(r_acc) >>> i_shift);
    assign zz   = (r_u >> 1) ^ (32'd0 - {31'd0, r_u[0]});
    always_comb begin
        case (i_cmd.esel)
            ESEL_WARM: smp = r_val;
            ESEL_RES:  smp = pred + zz;
            default:   smp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr) r_coef[i_tap] <= i_value;
        if (i_cmd.latch) r_val <= i_value;
        if (i_cmd.push) begin
            for (int i = MAX_ORDER - 1; i > 0; i--) r_hist[i] <= r_hist[i-1];
            r_hist[0] <= smp;
        end
        if (i_cmd.mac_mul) r_prod <= 32'(r_coef[i_cmd.mac_idx] * r_hist[i_cmd.mac_idx]);
        if (i_cmd.mac_clear) r_acc <= '0;
        else if (i_cmd.mac_add) r_acc <= r_acc + r_prod;
        if (i_cmd.u_clr) r_u <= '0;
        else if (i_cmd.u_inc) r_u <= (&r_u) ? r_u : r_u + 32'd1;
        else if (i_cmd.u_shift) r_u <= r_u << i_cmd.rice;
        else if (i_cmd.u_setbit) r_u <= r_u | (32'd1 << i_cmd.u_bitpos);
    end

    // pending result leaves only once its last flag is known
    assign out_free = !r_ov || i_m_tready;
    assign move = r_pv && out_free && (r_pl || i_cmd.emit || i_cmd.flush);
    assign o_stat.can_emit = !r_pv || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0; r_pl <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (move) begin
                r_ov <= 1'b1; r_os <= r_ps; r_oe <= r_pe; r_oerr <= r_perr;
                r_ol <= r_pl | i_cmd.flush;
            end else if (out_free) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pv <= 1'b1; r_pl <= 1'b0; r_ps <= smp;
                r_pe <= i_cmd.blk_end; r_perr <= i_cmd.err;
            end else if (move) begin
                r_pv <= 1'b0; r_pl <= 1'b0;
            end else if (i_cmd.flush && r_pv) begin
                r_pl <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_sample   = r_os;
    assign o_blk_end  = r_oe;
    assign o_err      = r_oerr;
    assign o_last     = r_ol;

endmodule

`default_nettype wire
